### rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the arithmetic encoder core.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cons holds in the same cycle as ante, outside reset.
`define BAE_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Check that cons holds in the cycle after ante, outside reset.
`define BAE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### rtl/core/bae_pkg.sv
// ----------------------------------------------------------------------------
// bae_pkg
// Widths, constants and types shared by the arithmetic encoder core.
// ----------------------------------------------------------------------------
package bae_pkg;

  // Field widths
  localparam int OP_W     = 2;
  localparam int FREQ_W   = 15;
  localparam int IV_W     = 16;
  localparam int FOLLOW_W = 16;
  localparam int TOTAL_W  = 32;

  // Datapath widths: range fits 18 signed bits, product 34, work values 36
  localparam int RANGE_W  = 18;
  localparam int PROD_W   = 34;
  localparam int WORK_W   = 36;
  localparam int SCALE_SH = 14;

  // Renormalization step limit
  localparam int MAX_STEPS = 16;
  localparam int STEP_W    = 5;

  // Interval constants
  localparam int HALF          = 32768;
  localparam int QUARTER       = 16384;
  localparam int THREE_QUARTER = 49152;
  localparam int TOP           = 65535;

  typedef enum logic [OP_W-1:0] {
    OP_ENCODE  = 2'd0,
    OP_FINISH  = 2'd1,
    OP_RESTART = 2'd2,
    OP_UNUSED  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_HI,
    ST_MUL_LO,
    ST_NARROW,
    ST_RENORM,
    ST_SINGLE
  } state_t;

  typedef enum logic [1:0] {
    RN_LEAD0,
    RN_LEAD1,
    RN_UNDER,
    RN_STOP
  } rn_kind_t;

  typedef enum logic [1:0] {
    OS_HOLD,
    OS_NOLEAD,
    OS_SINGLE
  } out_sel_t;

  // One renormalization step: decision and the shifted interval
  typedef struct packed {
    rn_kind_t                 kind;
    logic signed [WORK_W-1:0] lo;
    logic signed [WORK_W-1:0] hi;
  } rn_res_t;

endpackage

### rtl/core/bae_if.sv
// ----------------------------------------------------------------------------
// bae_if
// Valid/ready request and result channels of the arithmetic encoder core.
// ----------------------------------------------------------------------------
interface bae_in_if;
  import bae_pkg::*;

  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   operation;
  logic [FREQ_W-1:0] freq_upper;
  logic [FREQ_W-1:0] freq_lower;
  logic              is_first_symbol;

  modport source (
    output valid, operation, freq_upper, freq_lower, is_first_symbol,
    input  ready
  );
  modport sink (
    input  valid, operation, freq_upper, freq_lower, is_first_symbol,
    output ready
  );
endinterface

interface bae_out_if;
  import bae_pkg::*;

  logic                valid;
  logic                ready;
  logic                has_lead;
  logic                lead_bit;
  logic [FOLLOW_W-1:0] follow_count;
  logic [TOTAL_W-1:0]  total_bits;
  logic                last;

  modport source (
    output valid, has_lead, lead_bit, follow_count, total_bits, last,
    input  ready
  );
  modport sink (
    input  valid, has_lead, lead_bit, follow_count, total_bits, last,
    output ready
  );
endinterface

### rtl/core/bae_mul_unit.sv
// ----------------------------------------------------------------------------
// bae_mul_unit
// Shared registered multiplier: interval range times a cumulative frequency.
// ----------------------------------------------------------------------------
module bae_mul_unit (
  input  logic                                clk,
  input  logic                                en,
  input  logic signed [bae_pkg::RANGE_W-1:0]  mul_a,
  input  logic        [bae_pkg::FREQ_W-1:0]   mul_b,
  output logic signed [bae_pkg::PROD_W-1:0]   prod_r
);
  import bae_pkg::*;

  logic signed [PROD_W-1:0] prod_nxt;

  // Multiply signed range by zero-extended frequency
  assign prod_nxt = mul_a * $signed({1'b0, mul_b});

  // Hold the product until the next use
  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= prod_nxt;
    end
  end

endmodule

### rtl/core/bae_renorm_unit.sv
// ----------------------------------------------------------------------------
// bae_renorm_unit
// One renormalization step: classify the interval and shift it left once.
// ----------------------------------------------------------------------------
module bae_renorm_unit (
  input  logic signed [bae_pkg::WORK_W-1:0] lo,
  input  logic signed [bae_pkg::WORK_W-1:0] hi,
  output bae_pkg::rn_res_t                  res
);
  import bae_pkg::*;

  localparam logic signed [WORK_W-1:0] W_HALF    = WORK_W'(HALF);
  localparam logic signed [WORK_W-1:0] W_QUARTER = WORK_W'(QUARTER);
  localparam logic signed [WORK_W-1:0] W_THREE_Q = WORK_W'(THREE_QUARTER);

  rn_kind_t                 kind;
  logic signed [WORK_W-1:0] sub;
  logic signed [WORK_W-1:0] lo_s;
  logic signed [WORK_W-1:0] hi_s;

  // Pick the step kind; the first matching rule wins
  always_comb begin
    priority if (hi < W_HALF) begin
      kind = RN_LEAD0;
      sub  = '0;
    end else if (lo >= W_HALF) begin
      kind = RN_LEAD1;
      sub  = W_HALF;
    end else if ((lo >= W_QUARTER) && (hi < W_THREE_Q)) begin
      kind = RN_UNDER;
      sub  = W_QUARTER;
    end else begin
      kind = RN_STOP;
      sub  = '0;
    end
  end

  // Drop the offset, then double low and double-plus-one high
  assign lo_s = lo - sub;
  assign hi_s = hi - sub;
  assign res  = {kind, lo_s[WORK_W-2:0], 1'b0, hi_s[WORK_W-2:0], 1'b1};

endmodule

### rtl/core/binary_arithmetic_encoder.sv
// ----------------------------------------------------------------------------
// binary_arithmetic_encoder
// 16-bit arithmetic encoder with underflow (bits-to-follow) handling.
// ----------------------------------------------------------------------------
// The block takes one request at a time. An encode request uses the shared
// multiplier twice (range times upper, then range times lower frequency),
// narrows the interval, then takes renormalization shifts on the shared step
// unit, up to MAX_STEPS of them, and closes; a new encode request is taken
// only once it is done. Finish, restart and the unused code pass through a
// single state. Each lead bit leaves as one result; the last result of a
// request carries last. The held lead and the output register stall the block
// only while the sink holds ready low with a result already waiting.
module binary_arithmetic_encoder (
  input  logic      clk,
  input  logic      rst_n,
  bae_in_if.sink    in_ch,
  bae_out_if.source out_ch
);
  import bae_pkg::*;
  `include "assert_macros.svh"

  localparam logic [IV_W-1:0]     IV_TOP     = IV_W'(TOP);
  localparam logic [IV_W-1:0]     IV_QUARTER = IV_W'(QUARTER);
  localparam logic [FOLLOW_W-1:0] FOL_TOP    = FOLLOW_W'(TOP);
  localparam logic [STEP_W-1:0]   STEP_MAX   = STEP_W'(MAX_STEPS);

  // Sequencer
  state_t state_r, state_nxt;

  // Coder state
  logic [IV_W-1:0]     low_r, low_nxt;
  logic [IV_W-1:0]     high_r, high_nxt;
  logic [FOLLOW_W-1:0] pend_r, pend_nxt;
  logic [TOTAL_W-1:0]  bits_r, bits_nxt;

  // Request registers
  op_t               op_r, op_nxt;
  logic [FREQ_W-1:0] fu_r, fu_nxt;
  logic [FREQ_W-1:0] fl_r, fl_nxt;
  logic              first_r, first_nxt;

  // Work interval and step counter
  logic signed [WORK_W-1:0] wlo_r, wlo_nxt;
  logic signed [WORK_W-1:0] whi_r, whi_nxt;
  logic [STEP_W-1:0]        step_r, step_nxt;

  // Held lead result, released once the next lead or the end is known
  logic                hold_valid_r, hold_valid_nxt;
  logic                hold_bit_r, hold_bit_nxt;
  logic [FOLLOW_W-1:0] hold_follow_r, hold_follow_nxt;
  logic [TOTAL_W-1:0]  hold_total_r, hold_total_nxt;

  // Output register
  logic                out_valid_r, out_valid_nxt;
  logic                out_has_r, out_has_nxt;
  logic                out_bit_r, out_bit_nxt;
  logic [FOLLOW_W-1:0] out_follow_r, out_follow_nxt;
  logic [TOTAL_W-1:0]  out_total_r, out_total_nxt;
  logic                out_last_r, out_last_nxt;

  // Sequencer outputs
  logic     in_ready;
  logic     mul_en;
  logic     load_hi;
  logic     load_lo;
  logic     step_go;
  logic     commit;
  logic     single_go;
  logic     push;
  out_sel_t push_sel;

  logic in_accept;
  logic out_free;
  logic stopping;
  logic is_lead;

  logic signed [RANGE_W-1:0] range_w;
  logic        [FREQ_W-1:0]  mul_b;
  logic signed [PROD_W-1:0]  prod_r;
  logic signed [PROD_W-1:0]  prod_sh;
  logic signed [WORK_W-1:0]  scaled;
  logic signed [WORK_W-1:0]  lo0_ext;
  logic signed [WORK_W-1:0]  hi0_ext;
  rn_res_t                   rn;

  logic                s_has;
  logic                s_bit;
  logic [FOLLOW_W-1:0] s_follow;
  logic [TOTAL_W-1:0]  s_total;
  logic [FOLLOW_W-1:0] fin_follow;
  logic [TOTAL_W-1:0]  lead_total;

  assign in_accept = in_ch.valid && in_ready;
  assign out_free  = !out_valid_r || out_ch.ready;

  // Shared multiplier: range by upper, then by lower frequency
  assign range_w = $signed({{(RANGE_W-IV_W){1'b0}}, high_r})
                 - $signed({{(RANGE_W-IV_W){1'b0}}, low_r})
                 + RANGE_W'(1);
  assign mul_b   = (state_r == ST_MUL_HI) ? fu_r : fl_r;

  bae_mul_unit u_mul (
    .clk    (clk),
    .en     (mul_en),
    .mul_a  (range_w),
    .mul_b  (mul_b),
    .prod_r (prod_r)
  );

  // Floor-scale the product and extend the stored interval
  assign prod_sh = prod_r >>> SCALE_SH;
  assign scaled  = WORK_W'(prod_sh);
  assign lo0_ext = $signed({{(WORK_W-IV_W){1'b0}}, low_r});
  assign hi0_ext = $signed({{(WORK_W-IV_W){1'b0}}, high_r});

  // Shared renormalization step unit
  bae_renorm_unit u_renorm (
    .lo  (wlo_r),
    .hi  (whi_r),
    .res (rn)
  );

  assign is_lead  = (rn.kind == RN_LEAD0) || (rn.kind == RN_LEAD1);
  assign stopping = (rn.kind == RN_STOP) || (step_r == STEP_MAX);

  // Finish and restart results
  assign fin_follow = (pend_r == FOL_TOP) ? pend_r : pend_r + FOLLOW_W'(1);
  assign lead_total = bits_r + TOTAL_W'(pend_r) + TOTAL_W'(1);

  always_comb begin
    s_has    = 1'b0;
    s_bit    = 1'b0;
    s_follow = '0;
    s_total  = bits_r;
    unique case (op_r)
      OP_FINISH: begin
        s_has    = 1'b1;
        s_bit    = !(low_r < IV_QUARTER);
        s_follow = fin_follow;
        s_total  = bits_r + TOTAL_W'(fin_follow) + TOTAL_W'(1);
      end
      OP_RESTART: begin
        s_total = '0;
      end
      default: begin
        s_total = bits_r;
      end
    endcase
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          state_nxt = (op_t'(in_ch.operation) == OP_ENCODE) ? ST_MUL_HI : ST_SINGLE;
        end
      end
      ST_MUL_HI: state_nxt = ST_MUL_LO;
      ST_MUL_LO: state_nxt = ST_NARROW;
      ST_NARROW: state_nxt = ST_RENORM;
      ST_RENORM: begin
        if (commit) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_SINGLE: begin
        if (single_go) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_ready  = 1'b0;
    mul_en    = 1'b0;
    load_hi   = 1'b0;
    load_lo   = 1'b0;
    step_go   = 1'b0;
    commit    = 1'b0;
    single_go = 1'b0;
    push      = 1'b0;
    push_sel  = OS_HOLD;
    unique case (state_r)
      ST_IDLE: in_ready = 1'b1;
      ST_MUL_HI: mul_en = 1'b1;
      ST_MUL_LO: begin
        mul_en  = 1'b1;
        load_hi = 1'b1;
      end
      ST_NARROW: load_lo = 1'b1;
      ST_RENORM: begin
        if (stopping) begin
          if (out_free) begin
            commit   = 1'b1;
            push     = 1'b1;
            push_sel = hold_valid_r ? OS_HOLD : OS_NOLEAD;
          end
        end else if (is_lead) begin
          if (!hold_valid_r || out_free) begin
            step_go  = 1'b1;
            push     = hold_valid_r;
            push_sel = OS_HOLD;
          end
        end else begin
          step_go = 1'b1;
        end
      end
      ST_SINGLE: begin
        if (out_free) begin
          single_go = 1'b1;
          push      = 1'b1;
          push_sel  = OS_SINGLE;
        end
      end
      default: in_ready = 1'b0;
    endcase
  end

  // Register next values
  always_comb begin
    low_nxt         = low_r;
    high_nxt        = high_r;
    pend_nxt        = pend_r;
    bits_nxt        = bits_r;
    op_nxt          = op_r;
    fu_nxt          = fu_r;
    fl_nxt          = fl_r;
    first_nxt       = first_r;
    wlo_nxt         = wlo_r;
    whi_nxt         = whi_r;
    step_nxt        = step_r;
    hold_valid_nxt  = hold_valid_r;
    hold_bit_nxt    = hold_bit_r;
    hold_follow_nxt = hold_follow_r;
    hold_total_nxt  = hold_total_r;

    // Capture the request
    if (in_accept) begin
      op_nxt    = op_t'(in_ch.operation);
      fu_nxt    = in_ch.freq_upper;
      fl_nxt    = in_ch.freq_lower;
      first_nxt = in_ch.is_first_symbol;
    end

    // Narrow high, then low
    if (load_hi) begin
      whi_nxt = first_r ? hi0_ext : lo0_ext + scaled - WORK_W'(1);
    end
    if (load_lo) begin
      wlo_nxt  = lo0_ext + scaled;
      step_nxt = '0;
    end

    // Advance one renormalization step
    if (step_go) begin
      wlo_nxt  = $signed(rn.lo);
      whi_nxt  = $signed(rn.hi);
      step_nxt = step_r + STEP_W'(1);
      if (is_lead) begin
        bits_nxt        = lead_total;
        hold_valid_nxt  = 1'b1;
        hold_bit_nxt    = (rn.kind == RN_LEAD1);
        hold_follow_nxt = pend_r;
        hold_total_nxt  = lead_total;
        pend_nxt        = '0;
      end else if (pend_r != FOL_TOP) begin
        pend_nxt = pend_r + FOLLOW_W'(1);
      end
    end

    // Store the interval at the end of an encode
    if (commit) begin
      low_nxt        = wlo_r[IV_W-1:0];
      high_nxt       = whi_r[IV_W-1:0];
      hold_valid_nxt = 1'b0;
    end

    // Finish or restart the coder
    if (single_go && ((op_r == OP_FINISH) || (op_r == OP_RESTART))) begin
      low_nxt  = '0;
      high_nxt = IV_TOP;
      pend_nxt = '0;
      bits_nxt = s_total;
    end
  end

  // Output register: load on push, drop once taken
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_has_nxt    = out_has_r;
    out_bit_nxt    = out_bit_r;
    out_follow_nxt = out_follow_r;
    out_total_nxt  = out_total_r;
    out_last_nxt   = out_last_r;
    if (push) begin
      out_valid_nxt = 1'b1;
      unique case (push_sel)
        OS_HOLD: begin
          out_has_nxt    = 1'b1;
          out_bit_nxt    = hold_bit_r;
          out_follow_nxt = hold_follow_r;
          out_total_nxt  = hold_total_r;
          out_last_nxt   = commit;
        end
        OS_NOLEAD: begin
          out_has_nxt    = 1'b0;
          out_bit_nxt    = 1'b0;
          out_follow_nxt = '0;
          out_total_nxt  = bits_r;
          out_last_nxt   = 1'b1;
        end
        OS_SINGLE: begin
          out_has_nxt    = s_has;
          out_bit_nxt    = s_bit;
          out_follow_nxt = s_follow;
          out_total_nxt  = s_total;
          out_last_nxt   = 1'b1;
        end
        default: begin
          out_has_nxt    = 1'b0;
          out_bit_nxt    = 1'b0;
          out_follow_nxt = '0;
          out_total_nxt  = bits_r;
          out_last_nxt   = 1'b1;
        end
      endcase
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control and coder state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      low_r        <= '0;
      high_r       <= IV_TOP;
      pend_r       <= '0;
      bits_r       <= '0;
      step_r       <= '0;
      hold_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      low_r        <= low_nxt;
      high_r       <= high_nxt;
      pend_r       <= pend_nxt;
      bits_r       <= bits_nxt;
      step_r       <= step_nxt;
      hold_valid_r <= hold_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    op_r          <= op_nxt;
    fu_r          <= fu_nxt;
    fl_r          <= fl_nxt;
    first_r       <= first_nxt;
    wlo_r         <= wlo_nxt;
    whi_r         <= whi_nxt;
    hold_bit_r    <= hold_bit_nxt;
    hold_follow_r <= hold_follow_nxt;
    hold_total_r  <= hold_total_nxt;
    out_has_r     <= out_has_nxt;
    out_bit_r     <= out_bit_nxt;
    out_follow_r  <= out_follow_nxt;
    out_total_r   <= out_total_nxt;
    out_last_r    <= out_last_nxt;
  end

  // Drive the channels
  assign in_ch.ready         = in_ready;
  assign out_ch.valid        = out_valid_r;
  assign out_ch.has_lead     = out_has_r;
  assign out_ch.lead_bit     = out_bit_r;
  assign out_ch.follow_count = out_follow_r;
  assign out_ch.total_bits   = out_total_r;
  assign out_ch.last         = out_last_r;

  // Assertions
  `BAE_ASSERT_SAME(a_hold_idle, clk, rst_n, state_r == ST_IDLE, !hold_valid_r)
  `BAE_ASSERT_SAME(a_push_free, clk, rst_n, push, !out_valid_r || out_ch.ready)
  `BAE_ASSERT_NEXT(a_enc_start, clk, rst_n, in_accept && (in_ch.operation == OP_ENCODE), state_r == ST_MUL_HI)
  `BAE_ASSERT_SAME(a_step_max, clk, rst_n, state_r == ST_RENORM, step_r <= STEP_MAX)

endmodule

### sim/binary_arithmetic_encoder_checker.sv
// ----------------------------------------------------------------------------
// binary_arithmetic_encoder_checker
// Watches the request and result channels of the arithmetic encoder, predicts the code
// words that every accepted request produces and compares them in order.
// ----------------------------------------------------------------------------
module binary_arithmetic_encoder_checker (
  input  logic clk,
  input  logic rst_n,
  bae_in_if    in_mon,
  bae_out_if   out_mon,
  output int   fail_count,
  output int   words_waiting,
  output int   words_checked,
  output int   leads_predicted,
  output int   underflow_steps
);
  import bae_pkg::*;

  // One emitted code word as it leaves the block
  typedef struct packed {
    logic                has_lead;
    logic                lead_bit;
    logic [FOLLOW_W-1:0] follow_count;
    logic [TOTAL_W-1:0]  total_bits;
    logic                last;
  } code_word_t;

  // Coder state as the block should hold it
  logic [IV_W-1:0]     iv_low;
  logic [IV_W-1:0]     iv_high;
  logic [FOLLOW_W-1:0] follow_pend;
  logic [TOTAL_W-1:0]  bits_total;

  code_word_t word_q[$];

  function automatic void reinit_interval();
    iv_low      = '0;
    iv_high     = IV_W'(TOP);
    follow_pend = '0;
  endfunction

  // Narrow, renormalize or flush, and queue the code words this causes
  function automatic void predict_words(input op_t op, input logic [FREQ_W-1:0] fu,
                                        input logic [FREQ_W-1:0] fl, input logic first);
    longint              lo;
    longint              hi;
    longint              rng;
    longint              fu_l;
    longint              fl_l;
    code_word_t          word;
    bit                  have_word;
    logic [FOLLOW_W:0]   fol;
    word      = '0;
    have_word = 1'b0;
    unique case (op)
      OP_ENCODE: begin
        lo   = longint'(iv_low);
        hi   = longint'(iv_high);
        fu_l = longint'(fu);
        fl_l = longint'(fl);
        rng  = hi - lo + 1;
        if (!first) begin
          hi = lo + ((rng * fu_l) >>> SCALE_SH) - 1;
        end
        lo = lo + ((rng * fl_l) >>> SCALE_SH);
        for (int steps = 0; steps < MAX_STEPS; steps++) begin
          if (hi < HALF || lo >= HALF) begin
            // emit a lead bit with the pending opposite bits behind it
            if (have_word) begin
              word_q.push_back(word);
            end
            bits_total = bits_total + 32'd1 + {16'd0, follow_pend};
            word = '{has_lead: 1'b1, lead_bit: (hi >= HALF), follow_count: follow_pend,
                     total_bits: bits_total, last: 1'b0};
            have_word   = 1'b1;
            follow_pend = '0;
            leads_predicted++;
            if (hi >= HALF) begin
              lo -= HALF;
              hi -= HALF;
            end
          end else if (lo >= QUARTER && hi < THREE_QUARTER) begin
            // straddling the middle: defer the bit and count underflow
            if (follow_pend != FOLLOW_W'(TOP)) begin
              follow_pend = follow_pend + 1'b1;
            end
            lo -= QUARTER;
            hi -= QUARTER;
            underflow_steps++;
          end else begin
            break;
          end
          lo = lo * 2;
          hi = hi * 2 + 1;
        end
        iv_low  = lo[IV_W-1:0];
        iv_high = hi[IV_W-1:0];
        if (!have_word) begin
          word = '{has_lead: 1'b0, lead_bit: 1'b0, follow_count: '0,
                   total_bits: bits_total, last: 1'b1};
        end
      end
      OP_FINISH: begin
        fol = {1'b0, follow_pend} + 1'b1;
        if (fol > TOP) begin
          fol = (FOLLOW_W+1)'(TOP);
        end
        bits_total = bits_total + 32'd1 + {15'd0, fol};
        word = '{has_lead: 1'b1, lead_bit: (iv_low >= QUARTER), follow_count: fol[FOLLOW_W-1:0],
                 total_bits: bits_total, last: 1'b1};
        reinit_interval();
      end
      OP_RESTART: begin
        reinit_interval();
        bits_total = '0;
        word = '{has_lead: 1'b0, lead_bit: 1'b0, follow_count: '0, total_bits: '0, last: 1'b1};
      end
      default: begin
        word = '{has_lead: 1'b0, lead_bit: 1'b0, follow_count: '0,
                 total_bits: bits_total, last: 1'b1};
      end
    endcase
    word.last = 1'b1;
    word_q.push_back(word);
  endfunction

  // Compare four-state so an unknown result bit counts as a mismatch
  function automatic void check_field(input string name, input logic [TOTAL_W-1:0] exp_v,
                                      input logic [TOTAL_W-1:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
      fail_count++;
    end
  endfunction

  // Predict on each accepted request, compare each accepted result
  always @(posedge clk) begin
    code_word_t want;
    if (!rst_n) begin
      reinit_interval();
      bits_total      = '0;
      word_q.delete();
      fail_count      = 0;
      words_checked   = 0;
      leads_predicted = 0;
      underflow_steps = 0;
    end else begin
      if (in_mon.valid && in_mon.ready) begin
        predict_words(op_t'(in_mon.operation), in_mon.freq_upper, in_mon.freq_lower,
                      in_mon.is_first_symbol);
      end
      if (out_mon.valid && out_mon.ready) begin
        if (word_q.size() == 0) begin
          $error("unexpected result: has_lead %0d lead_bit %0d follow_count %0d total_bits %0d",
                 out_mon.has_lead, out_mon.lead_bit, out_mon.follow_count,
                 out_mon.total_bits);
          fail_count++;
        end else begin
          want = word_q.pop_front();
          check_field("has_lead", TOTAL_W'(want.has_lead), TOTAL_W'(out_mon.has_lead));
          check_field("lead_bit", TOTAL_W'(want.lead_bit), TOTAL_W'(out_mon.lead_bit));
          check_field("follow_count", TOTAL_W'(want.follow_count),
                      TOTAL_W'(out_mon.follow_count));
          check_field("total_bits", want.total_bits, out_mon.total_bits);
          check_field("last", TOTAL_W'(want.last), TOTAL_W'(out_mon.last));
          words_checked++;
        end
      end
    end
    words_waiting = word_q.size();
  end

endmodule

### sim/binary_arithmetic_encoder_tb.sv
// ----------------------------------------------------------------------------
// binary_arithmetic_encoder_tb
// Drives directed and random encode, finish, restart and unused requests into
// the arithmetic encoder with random gaps and output stalls, one long output
// hold-off, and leaves prediction and comparison to the checker.
// ----------------------------------------------------------------------------
module binary_arithmetic_encoder_tb;
  import bae_pkg::*;

  localparam int RAND_ITEMS   = 180;
  localparam int CALM_ITEMS   = 30;
  localparam int HOLD_CYCLES  = 120;
  localparam int DRAIN_CYCLES = 40;
  localparam int LIMIT_CYCLES = 200000;

  logic clk = 1'b0;
  logic rst_n;

  bae_in_if  in_ch ();
  bae_out_if out_ch ();

  bit calm;
  bit hold_off_req;
  bit hold_done;
  int cycle_count;
  int op_count[4];

  int fail_count;
  int words_waiting;
  int words_checked;
  int leads_predicted;
  int underflow_steps;

  always #10 clk = ~clk;

  binary_arithmetic_encoder u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  binary_arithmetic_encoder_checker u_chk (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_mon          (in_ch),
    .out_mon         (out_ch),
    .fail_count      (fail_count),
    .words_waiting   (words_waiting),
    .words_checked   (words_checked),
    .leads_predicted (leads_predicted),
    .underflow_steps (underflow_steps)
  );

  // Bound the run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycle_count,
               words_waiting);
      $display("Regression FAIL");
      $finish;
    end
  end

  // Result side: short random stalls, one long hold-off, none near the end
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req && !hold_done) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
        out_ch.ready <= 1'b1;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Offer one request and hold it until taken, then maybe leave a gap
  task automatic offer(input op_t op, input logic [FREQ_W-1:0] fu,
                       input logic [FREQ_W-1:0] fl, input logic first);
    in_ch.valid           <= 1'b1;
    in_ch.operation       <= op;
    in_ch.freq_upper      <= fu;
    in_ch.freq_lower      <= fl;
    in_ch.is_first_symbol <= first;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    op_count[int'(op)]++;
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  initial begin
    int                  pick;
    int                  width;
    int                  sent;
    logic [FREQ_W-1:0]   fu;
    logic [FREQ_W-1:0]   fl;
    in_ch.valid           <= 1'b0;
    in_ch.operation       <= OP_ENCODE;
    in_ch.freq_upper      <= '0;
    in_ch.freq_lower      <= '0;
    in_ch.is_first_symbol <= 1'b0;
    rst_n                 <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: full range, underflow, leads of both values, flushes, odd codes
    offer(OP_ENCODE, 15'd0, 15'd0, 1'b1);
    offer(OP_ENCODE, 15'd16384, 15'd0, 1'b0);
    offer(OP_ENCODE, 15'd12288, 15'd4096, 1'b0);
    offer(OP_ENCODE, 15'd8192, 15'd0, 1'b0);
    offer(OP_ENCODE, 15'd16384, 15'd12288, 1'b0);
    offer(OP_ENCODE, 15'd8193, 15'd8192, 1'b0);
    offer(OP_ENCODE, 15'd12288, 15'd4096, 1'b0);
    offer(OP_FINISH, 15'd0, 15'd0, 1'b0);
    offer(OP_ENCODE, 15'd16384, 15'd6000, 1'b0);
    offer(OP_FINISH, 15'h7fff, 15'h7fff, 1'b1);
    offer(OP_FINISH, 15'd0, 15'd0, 1'b0);
    offer(OP_UNUSED, 15'd0, 15'd0, 1'b0);
    offer(OP_ENCODE, 15'd9000, 15'd3000, 1'b0);
    offer(OP_RESTART, 15'd0, 15'd0, 1'b0);
    // degenerate intervals and out-of-scale frequencies
    offer(OP_ENCODE, 15'd0, 15'd0, 1'b0);
    offer(OP_ENCODE, 15'h7fff, 15'h7fff, 1'b0);
    offer(OP_ENCODE, 15'd0, 15'h7fff, 1'b1);
    offer(OP_ENCODE, 15'd16384, 15'd16384, 1'b0);
    offer(OP_ENCODE, 15'd100, 15'd5000, 1'b0);
    offer(OP_FINISH, 15'h2aaa, 15'h5555, 1'b1);
    offer(OP_RESTART, 15'h7fff, 15'h7fff, 1'b1);
    offer(OP_UNUSED, 15'h7fff, 15'h7fff, 1'b1);

    // Random: mostly well-formed symbols, some flushes and noise
    sent = 0;
    while (sent < RAND_ITEMS) begin
      calm = (sent >= RAND_ITEMS - CALM_ITEMS);
      if (sent == 20) begin
        hold_off_req = 1'b1;
      end
      pick = $urandom_range(0, 99);
      if (pick < 72) begin
        // narrow widths force long renormalization runs
        width = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 64) : $urandom_range(1, 16384);
        fl = FREQ_W'($urandom_range(0, 16384 - width));
        fu = fl + FREQ_W'(width);
        if ($urandom_range(0, 5) == 0) begin
          offer(OP_ENCODE, FREQ_W'($urandom_range(0, 32767)), fl, 1'b1);
        end else begin
          offer(OP_ENCODE, fu, fl, 1'b0);
        end
      end else if (pick < 82) begin
        offer(OP_FINISH, FREQ_W'($urandom), FREQ_W'($urandom), 1'($urandom));
      end else if (pick < 86) begin
        offer(OP_RESTART, FREQ_W'($urandom), FREQ_W'($urandom), 1'($urandom));
      end else if (pick < 90) begin
        offer(OP_UNUSED, FREQ_W'($urandom), FREQ_W'($urandom), 1'($urandom));
      end else begin
        offer(OP_ENCODE, FREQ_W'($urandom_range(0, 32767)), FREQ_W'($urandom_range(0, 32767)),
              1'($urandom));
      end
      sent++;
    end
    in_ch.valid <= 1'b0;

    // Drain outstanding results, then let the block settle
    while (words_waiting != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d encode, %0d finish, %0d restart, %0d unused requests, %0d results",
             op_count[int'(OP_ENCODE)], op_count[int'(OP_FINISH)],
             op_count[int'(OP_RESTART)], op_count[int'(OP_UNUSED)], words_checked);
    $display("Saw %0d lead bits and %0d underflow steps, with one %0d-cycle output hold-off",
             leads_predicted, underflow_steps, HOLD_CYCLES);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
